// ===== hw/rtl/hslp_pkg.sv =====
package hslp_pkg;

    // Parse phases, one per expected element of the status line, plus PH_SKIP after an error
    typedef enum logic [3:0] {
        PH_H1     = 4'd0,
        PH_T1     = 4'd1,
        PH_T2     = 4'd2,
        PH_P      = 4'd3,
        PH_SLASH  = 4'd4,
        PH_MAJOR  = 4'd5,
        PH_DOT    = 4'd6,
        PH_MINOR  = 4'd7,
        PH_SP1    = 4'd8,
        PH_CODE1  = 4'd9,
        PH_CODE2  = 4'd10,
        PH_CODE3  = 4'd11,
        PH_SP2    = 4'd12,
        PH_REASON = 4'd13,
        PH_LF     = 4'd14,
        PH_SKIP   = 4'd15
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_REASON = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NAME     = 4'd0,
        ERR_SLASH    = 4'd1,
        ERR_MAJOR    = 4'd2,
        ERR_DOT      = 4'd3,
        ERR_MINOR    = 4'd4,
        ERR_SPACE1   = 4'd5,
        ERR_CODE     = 4'd6,
        ERR_SPACE2   = 4'd7,
        ERR_LINE_END = 4'd8
    } t_err;

    localparam int COL_W  = 16;
    localparam int CODE_W = 10;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        reason_byte;
        logic [3:0]        version_major;
        logic [3:0]        version_minor;
        logic [CODE_W-1:0] status_code;
        logic [3:0]        error_code;
        logic [7:0]        error_byte;
        logic [COL_W-1:0]  error_column;
    } t_result;

endpackage

// ===== hw/rtl/hslp_parse.sv =====
module hslp_parse import hslp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data_byte,
    input  logic       i_strict,
    output t_result    o_result
);

    t_phase            r_phase,  n_phase;
    logic [3:0]        r_major,  n_major;
    logic [3:0]        r_minor,  n_minor;
    logic [CODE_W-1:0] r_code,   n_code;
    logic [COL_W-1:0]  r_col,    n_col;
    logic              r_extra,  n_extra;

    logic              err;
    t_err              err_code;
    logic              done;
    logic              is_digit;
    logic              is_reason;
    logic [3:0]        digit;
    logic [CODE_W+3:0] code_x10;

    assign is_digit  = (i_data_byte >= 8'h30) && (i_data_byte <= 8'h39);
    assign is_reason = (i_data_byte == 8'h09) || (i_data_byte == 8'h20)
                    || ((i_data_byte >= 8'h21) && (i_data_byte <= 8'h7E))
                    || i_data_byte[7];
    assign digit     = i_data_byte[3:0];
    // code * 10 as two shifts and an add
    assign code_x10  = {r_code, 3'b000} + {2'b00, r_code, 1'b0};

    always_comb begin
        n_phase  = r_phase;
        n_major  = r_major;
        n_minor  = r_minor;
        n_code   = r_code;
        n_extra  = r_extra;
        n_col    = (r_col == {COL_W{1'b1}}) ? r_col : r_col + 1'b1;
        err      = 1'b0;
        err_code = ERR_NAME;
        done     = 1'b0;
        o_result = '0;

        unique case (r_phase)
            PH_H1: begin
                if (i_data_byte == 8'h48) n_phase = PH_T1;
                else err = 1'b1;
            end
            PH_T1: begin
                if (i_data_byte == 8'h54) n_phase = PH_T2;
                else err = 1'b1;
            end
            PH_T2: begin
                if (i_data_byte == 8'h54) n_phase = PH_P;
                else err = 1'b1;
            end
            PH_P: begin
                if (i_data_byte == 8'h50) n_phase = PH_SLASH;
                else err = 1'b1;
            end
            PH_SLASH: begin
                if (i_data_byte == 8'h2F) n_phase = PH_MAJOR;
                else begin err = 1'b1; err_code = ERR_SLASH; end
            end
            PH_MAJOR: begin
                if (is_digit) begin
                    n_major = digit;
                    n_phase = PH_DOT;
                end else begin
                    err = 1'b1; err_code = ERR_MAJOR;
                end
            end
            PH_DOT: begin
                if (i_data_byte == 8'h2E) n_phase = PH_MINOR;
                else begin err = 1'b1; err_code = ERR_DOT; end
            end
            PH_MINOR: begin
                if (is_digit) begin
                    n_minor = digit;
                    n_phase = PH_SP1;
                end else begin
                    err = 1'b1; err_code = ERR_MINOR;
                end
            end
            PH_SP1: begin
                if (i_data_byte == 8'h20) begin
                    n_phase = PH_CODE1;
                    n_extra = 1'b0;
                    n_code  = '0;
                end else begin
                    err = 1'b1; err_code = ERR_SPACE1;
                end
            end
            PH_CODE1: begin
                if (i_data_byte == 8'h20) begin
                    if (i_strict && r_extra) begin
                        err = 1'b1; err_code = ERR_CODE;
                    end else begin
                        n_extra = 1'b1;
                    end
                end else if (is_digit) begin
                    n_code  = {{(CODE_W-4){1'b0}}, digit};
                    n_phase = PH_CODE2;
                end else begin
                    err = 1'b1; err_code = ERR_CODE;
                end
            end
            PH_CODE2, PH_CODE3: begin
                if (is_digit) begin
                    n_code  = code_x10[CODE_W-1:0] + {{(CODE_W-4){1'b0}}, digit};
                    n_phase = (r_phase == PH_CODE2) ? PH_CODE3 : PH_SP2;
                end else begin
                    err = 1'b1; err_code = ERR_CODE;
                end
            end
            PH_SP2: begin
                if (i_data_byte == 8'h20) n_phase = PH_REASON;
                else begin err = 1'b1; err_code = ERR_SPACE2; end
            end
            PH_REASON: begin
                if (is_reason) begin
                    o_result.kind        = KIND_REASON;
                    o_result.reason_byte = i_data_byte;
                end else if (i_data_byte == 8'h0D) begin
                    n_phase = PH_LF;
                end else if (i_data_byte == 8'h0A) begin
                    done = 1'b1;
                end else begin
                    err = 1'b1; err_code = ERR_LINE_END;
                end
            end
            PH_LF: begin
                if (i_data_byte == 8'h0A) done = 1'b1;
                else begin err = 1'b1; err_code = ERR_LINE_END; end
            end
            PH_SKIP: begin
                if (i_data_byte == 8'h0A) done = 1'b1;
            end
        endcase

        if (err) begin
            o_result.kind         = KIND_ERROR;
            o_result.error_code   = err_code;
            o_result.error_byte   = i_data_byte;
            o_result.error_column = r_col;
            n_phase = PH_SKIP;
        end

        if (done && r_phase != PH_SKIP) begin
            o_result.kind          = KIND_DONE;
            o_result.version_major = r_major;
            o_result.version_minor = r_minor;
            o_result.status_code   = r_code;
        end

        // line end (completed, skipped, or the failing byte itself) starts a new line
        if (done || (err && i_data_byte == 8'h0A)) begin
            n_phase = PH_H1;
            n_major = '0;
            n_minor = '0;
            n_code  = '0;
            n_col   = '0;
            n_extra = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_H1;
            r_major <= '0;
            r_minor <= '0;
            r_code  <= '0;
            r_col   <= '0;
            r_extra <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_major <= n_major;
            r_minor <= n_minor;
            r_code  <= n_code;
            r_col   <= n_col;
            r_extra <= n_extra;
        end
    end

    a_col_reset_on_h1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_H1) |-> (r_col == '0))
        else $error("column not zero at line start");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_REASON || r_phase == PH_SP2) |-> (r_code <= 10'd999))
        else $error("status code out of range");

endmodule

// ===== hw/rtl/hslp_obuf.sv =====
module hslp_obuf import hslp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_can_push,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop        = r_main_valid && i_ready;
    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_result   = r_main;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (pop) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                n_main       = i_result;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_main_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    a_skid_implies_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry without main entry");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("push into full buffer");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && pop) |=> (r_main_valid && !r_skid_valid))
        else $error("skid entry lost on pop");

endmodule

// ===== hw/rtl/http_status_line_parser.sv =====
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+------------------------------------------
// in       | i_in_valid  | o_in_ready  | i_data_byte
// out      | o_out_valid | i_out_ready | o_kind .. o_error_column (one result)
// cfg      | i_cfg_valid | o_cfg_ready | i_strict_spacing
//
// One byte per cycle while the output buffer has room; each byte beat yields exactly
// one result beat, registered in the output buffer. The parse state machine is
// combinational next-state logic (compare, x10 add, saturating column increment).
// A two-entry output buffer (main + skid) keeps o_in_ready registered: input
// stalls only once both entries are held by a stalled output side.
// Reset is synchronous active low; it clears the parse state and the buffer,
// and strict spacing returns to 0. No clearing pass; ready right after reset.
module http_status_line_parser import hslp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_data_byte,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_reason_byte,
    output logic [3:0]        o_version_major,
    output logic [3:0]        o_version_minor,
    output logic [CODE_W-1:0] o_status_code,
    output logic [3:0]        o_error_code,
    output logic [7:0]        o_error_byte,
    output logic [COL_W-1:0]  o_error_column,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_strict_spacing
);

    logic    r_strict;
    logic    in_beat;
    logic    can_push;
    t_result step_result;
    t_result out_result;

    // config writes must arrive only while idle (the user's duty; not enforced here); always take them
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b0;
        end else if (i_cfg_valid) begin
            r_strict <= i_strict_spacing;
        end
    end

    assign o_in_ready = can_push;
    assign in_beat    = i_in_valid && can_push;

    // state machine: advances on every accepted byte beat
    hslp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_beat),
        .i_data_byte (i_data_byte),
        .i_strict    (r_strict),
        .o_result    (step_result)
    );

    // result register with skid entry
    hslp_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (in_beat),
        .i_result   (step_result),
        .o_can_push (can_push),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_kind          = out_result.kind;
    assign o_reason_byte   = out_result.reason_byte;
    assign o_version_major = out_result.version_major;
    assign o_version_minor = out_result.version_minor;
    assign o_status_code   = out_result.status_code;
    assign o_error_code    = out_result.error_code;
    assign o_error_byte    = out_result.error_byte;
    assign o_error_column  = out_result.error_column;

    a_result_fields_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_REASON) |->
            (o_status_code == '0 && o_error_column == '0 && o_error_code == '0))
        else $error("stray fields on reason beat");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import hslp_pkg::*;

    // Run limits and pacing
    localparam int  CYCLE_LIMIT  = 1_000_000;
    localparam int  PHASE_BEATS  = 300;      // minimum byte beats per random phase (whole lines)
    localparam int  HOLD_AT      = 800;      // byte count that starts the long output stall
    localparam int  HOLD_CYCLES  = 80;
    localparam int  LONG_REASON  = 100;      // reason bytes in the long line
    localparam int  IDLE_PCT     = 19;
    localparam int  PRINT_CAP    = 100;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7F;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Byte input channel
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [7:0]       data_byte = 8'h00;

    // Result output channel
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [1:0]       kind;
    logic [7:0]       reason_byte;
    logic [3:0]       version_major;
    logic [3:0]       version_minor;
    logic [CODE_W-1:0] status_code;
    logic [3:0]       error_code;
    logic [7:0]       error_byte;
    logic [COL_W-1:0] error_column;

    // Configuration channel
    logic             cfg_valid      = 1'b0;
    logic             cfg_ready;
    logic             strict_spacing = 1'b0;

    http_status_line_parser dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_data_byte      (data_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_kind           (kind),
        .o_reason_byte    (reason_byte),
        .o_version_major  (version_major),
        .o_version_minor  (version_minor),
        .o_status_code    (status_code),
        .o_error_code     (error_code),
        .o_error_byte     (error_byte),
        .o_error_column   (error_column),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_strict_spacing (strict_spacing)
    );

    // ------------------------------------------------------------------
    // Shadow parser state; mirrors the block's status line state machine
    // ------------------------------------------------------------------
    t_phase           sh_phase;
    logic [3:0]       sh_major;
    logic [3:0]       sh_minor;
    logic [CODE_W-1:0] sh_code;
    logic [COL_W-1:0] sh_col;
    bit               sh_extra;
    bit               sh_strict;

    t_result          parse_results[$];   // results still owed by the block, oldest first
    logic [7:0]       line_buf[$];        // bytes of the line being generated

    int  mismatch_count = 0;
    int  sent_count     = 0;
    int  cycle_count    = 0;
    bit  idle_on        = 1'b1;
    bit  hold_used      = 1'b0;
    int  hold_left      = 0;

    // Directed stimulus table
    typedef struct {
        logic [7:0] data;
        bit         typed;   // want is filled in by hand
        t_result    want;
    } t_row;

    t_row dir_rows[$];

    // Start of a new line: clears digits, code, space flag and column
    function automatic void line_start();
        sh_phase = PH_H1;
        sh_major = '0;
        sh_minor = '0;
        sh_code  = '0;
        sh_col   = '0;
        sh_extra = 1'b0;
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic bit is_reason(logic [7:0] b);
        return (b == CH_TAB) || (b == CH_SP) || (b >= "!" && b <= "~") || (b >= 8'h80);
    endfunction

    // One byte through the shadow parser; returns the result it owes
    function automatic t_result parse_byte(logic [7:0] b);
        t_result          r;
        logic [COL_W-1:0] col;
        bit               fail;
        t_err             why;
        r    = '0;
        col  = sh_col;
        fail = 1'b0;
        why  = ERR_NAME;
        if (sh_col != '1)
            sh_col = sh_col + 1'b1;
        case (sh_phase)
            PH_H1:    if (b == "H") sh_phase = PH_T1;    else fail = 1'b1;
            PH_T1:    if (b == "T") sh_phase = PH_T2;    else fail = 1'b1;
            PH_T2:    if (b == "T") sh_phase = PH_P;     else fail = 1'b1;
            PH_P:     if (b == "P") sh_phase = PH_SLASH; else fail = 1'b1;
            PH_SLASH: begin
                if (b == "/") sh_phase = PH_MAJOR;
                else begin fail = 1'b1; why = ERR_SLASH; end
            end
            PH_MAJOR: begin
                if (is_digit(b)) begin
                    sh_major = 4'(b - "0");
                    sh_phase = PH_DOT;
                end else begin
                    fail = 1'b1; why = ERR_MAJOR;
                end
            end
            PH_DOT: begin
                if (b == ".") sh_phase = PH_MINOR;
                else begin fail = 1'b1; why = ERR_DOT; end
            end
            PH_MINOR: begin
                if (is_digit(b)) begin
                    sh_minor = 4'(b - "0");
                    sh_phase = PH_SP1;
                end else begin
                    fail = 1'b1; why = ERR_MINOR;
                end
            end
            PH_SP1: begin
                if (b == CH_SP) begin
                    sh_phase = PH_CODE1;
                    sh_extra = 1'b0;
                    sh_code  = '0;
                end else begin
                    fail = 1'b1; why = ERR_SPACE1;
                end
            end
            PH_CODE1: begin
                if (b == CH_SP) begin
                    // strict mode tolerates only one extra space
                    if (sh_strict && sh_extra) begin fail = 1'b1; why = ERR_CODE; end
                    else sh_extra = 1'b1;
                end else if (is_digit(b)) begin
                    sh_code  = CODE_W'(b - "0");
                    sh_phase = PH_CODE2;
                end else begin
                    fail = 1'b1; why = ERR_CODE;
                end
            end
            PH_CODE2, PH_CODE3: begin
                if (is_digit(b)) begin
                    sh_code  = CODE_W'(sh_code * 10 + (b - "0"));
                    sh_phase = (sh_phase == PH_CODE2) ? PH_CODE3 : PH_SP2;
                end else begin
                    fail = 1'b1; why = ERR_CODE;
                end
            end
            PH_SP2: begin
                if (b == CH_SP) sh_phase = PH_REASON;
                else begin fail = 1'b1; why = ERR_SPACE2; end
            end
            PH_REASON, PH_LF: begin
                if (sh_phase == PH_REASON && is_reason(b)) begin
                    r.kind        = KIND_REASON;
                    r.reason_byte = b;
                end else if (sh_phase == PH_REASON && b == CH_CR) begin
                    sh_phase = PH_LF;
                end else if (b == CH_LF) begin
                    r.kind          = KIND_DONE;
                    r.version_major = sh_major;
                    r.version_minor = sh_minor;
                    r.status_code   = sh_code;
                    line_start();
                end else begin
                    fail = 1'b1; why = ERR_LINE_END;
                end
            end
            default: begin
                // skipping after an error, through the next LF
                if (b == CH_LF) line_start();
                else sh_phase = PH_SKIP;
            end
        endcase
        if (fail) begin
            r.kind         = KIND_ERROR;
            r.error_code   = why;
            r.error_byte   = b;
            r.error_column = col;
            if (b == CH_LF) line_start();
            else sh_phase = PH_SKIP;
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, int got, int want);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Table row: a = error code or major, c = column or minor, d = status code
    task automatic add_row(logic [7:0] b, bit typed, t_kind k = KIND_NONE,
                           int a = 0, int c = 0, int d = 0);
        t_row row;
        row.data      = b;
        row.typed     = typed;
        row.want      = '0;
        row.want.kind = k;
        case (k)
            KIND_REASON: row.want.reason_byte = b;
            KIND_DONE: begin
                row.want.version_major = 4'(a);
                row.want.version_minor = 4'(c);
                row.want.status_code   = CODE_W'(d);
            end
            KIND_ERROR: begin
                row.want.error_code   = 4'(a);
                row.want.error_byte   = b;
                row.want.error_column = COL_W'(c);
            end
            default: ;
        endcase
        dir_rows.push_back(row);
    endtask

    // Offer one byte beat; entered and left at a falling edge.
    // The expectation is taken when the beat is accepted.
    task automatic send_byte(logic [7:0] b, bit typed = 1'b0, t_result want = '0);
        t_result r;
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = parse_byte(b);
        parse_results.push_back(typed ? want : r);
        sent_count++;
        @(negedge clk);
    endtask

    // Register write, only once every owed result is back
    task automatic set_spacing(bit v);
        in_valid <= 1'b0;
        while (parse_results.size() != 0) @(negedge clk);
        cfg_valid      <= 1'b1;
        strict_spacing <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sh_strict = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_reason_byte();
        case ($urandom_range(0, 3))
            0:       return ($urandom_range(0, 1) != 0) ? CH_TAB : CH_SP;
            1, 2:    return 8'($urandom_range(8'h21, 8'h7E));
            default: return 8'($urandom_range(8'h80, 8'hFF));
        endcase
    endfunction

    // Bytes that tend to land on the interesting branches
    function automatic logic [7:0] rand_bad_byte();
        case ($urandom_range(0, 7))
            0:       return CH_SP;
            1:       return CH_CR;
            2:       return CH_LF;
            3:       return CH_DEL;
            4:       return 8'h00;
            5:       return CH_TAB;
            6:       return 8'("0" + $urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed status lines, some corrupted, a few pure noise
    task automatic build_line();
        int n;
        int pick;
        int pos;
        line_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick >= 92) begin
            n = $urandom_range(1, 6);
            repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
            line_buf.push_back(CH_LF);
        end else begin
            line_buf.push_back("H");
            line_buf.push_back("T");
            line_buf.push_back("T");
            line_buf.push_back("P");
            line_buf.push_back("/");
            line_buf.push_back(8'("0" + $urandom_range(0, 9)));
            line_buf.push_back(".");
            line_buf.push_back(8'("0" + $urandom_range(0, 9)));
            line_buf.push_back(CH_SP);
            // extra spaces: two of them break strict mode
            n = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, sh_strict ? 2 : 4);
            repeat (n) line_buf.push_back(CH_SP);
            repeat (3) line_buf.push_back(8'("0" + $urandom_range(0, 9)));
            line_buf.push_back(CH_SP);
            n = $urandom_range(0, 14);
            repeat (n) line_buf.push_back(rand_reason_byte());
            if ($urandom_range(0, 1) != 0) line_buf.push_back(CH_CR);
            line_buf.push_back(CH_LF);
            if (pick >= 70) begin
                pos = $urandom_range(0, line_buf.size() - 1);
                if ($urandom_range(0, 1) != 0) line_buf[pos] = rand_bad_byte();
                else line_buf.insert(pos, rand_bad_byte());
                if (line_buf[line_buf.size() - 1] != CH_LF) line_buf.push_back(CH_LF);
            end
        end
    endtask

    task automatic random_phase(int beats);
        int start;
        start = sent_count;
        while (sent_count - start < beats) begin
            build_line();
            foreach (line_buf[i]) send_byte(line_buf[i]);
        end
    endtask

    // Output side: random stalls, plus one long hold-off while bytes keep coming
    always @(negedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_used && sent_count >= HOLD_AT) begin
            out_ready <= 1'b0;
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
        end else begin
            out_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Result beats, compared with the oldest owed result
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (parse_results.size() == 0) begin
                note_mismatch("result with nothing owed, kind", int'(kind), -1);
            end else begin
                want = parse_results.pop_front();
                if (kind != want.kind)
                    note_mismatch("kind", int'(kind), int'(want.kind));
                if (reason_byte != want.reason_byte)
                    note_mismatch("reason_byte", int'(reason_byte), int'(want.reason_byte));
                if (version_major != want.version_major)
                    note_mismatch("version_major", int'(version_major),
                                  int'(want.version_major));
                if (version_minor != want.version_minor)
                    note_mismatch("version_minor", int'(version_minor),
                                  int'(want.version_minor));
                if (status_code != want.status_code)
                    note_mismatch("status_code", int'(status_code), int'(want.status_code));
                if (error_code != want.error_code)
                    note_mismatch("error_code", int'(error_code), int'(want.error_code));
                if (error_byte != want.error_byte)
                    note_mismatch("error_byte", int'(error_byte), int'(want.error_byte));
                if (error_column != want.error_column)
                    note_mismatch("error_column", int'(error_column),
                                  int'(want.error_column));
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: errors");
        $finish;
    end

    // Main sequence
    initial begin
        sh_strict = 1'b0;
        line_start();

        // Directed rows; strict spacing is still at its reset value of 0
        add_row(8'h00, 1, KIND_ERROR, ERR_NAME, 0);       // bad first byte, column 0
        add_row("A",   1);                                // skipped
        add_row(CH_LF, 1);                                // ends the skip
        add_row(CH_LF, 1, KIND_ERROR, ERR_NAME, 0);       // LF as failing byte restarts at once
        add_row("H", 1);
        add_row("T", 1);
        add_row("T", 1);
        add_row("P", 1);
        add_row("/", 1);
        add_row("9", 1);
        add_row(".", 1);
        add_row("0", 1);
        add_row(CH_SP, 1);
        add_row(CH_SP, 0);                                // two extra spaces, fine when loose
        add_row(CH_SP, 0);
        add_row("9", 0);
        add_row("9", 0);
        add_row("9", 0);
        add_row(CH_SP, 0);
        add_row(8'hFF, 1, KIND_REASON);                   // top of the reason range
        add_row(CH_TAB, 0);
        add_row(CH_CR, 0);
        add_row(CH_LF, 1, KIND_DONE, 9, 0, 999);          // CRLF closes the line
        add_row("H", 0);
        add_row(CH_DEL, 1, KIND_ERROR, ERR_NAME, 1);      // DEL where T belongs
        add_row(CH_LF, 0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i]) send_byte(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);

        // Random phases across both spacing modes
        set_spacing(1'b1);
        random_phase(PHASE_BEATS);

        set_spacing(1'b0);
        idle_on = 1'b0;                                   // back-to-back beats, no stalls
        random_phase(PHASE_BEATS);
        idle_on = 1'b1;

        set_spacing(1'b1);
        random_phase(PHASE_BEATS);                        // output hold-off lands here

        // A long reason phrase, then a control byte that breaks it
        set_spacing(1'b0);
        line_buf.delete();
        send_byte("H");
        send_byte("T");
        send_byte("T");
        send_byte("P");
        send_byte("/");
        send_byte("1");
        send_byte(".");
        send_byte("1");
        send_byte(CH_SP);
        send_byte("2");
        send_byte("0");
        send_byte("0");
        send_byte(CH_SP);
        repeat (LONG_REASON) send_byte(rand_reason_byte());
        send_byte(8'h01);                                 // control byte in the reason
        send_byte(CH_LF);
        random_phase(PHASE_BEATS);

        set_spacing(1'b1);
        random_phase(PHASE_BEATS);

        // Drain
        in_valid <= 1'b0;
        while (parse_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);

        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== http_status_line_parser.f =====
hw/rtl/hslp_pkg.sv
hw/rtl/hslp_parse.sv
hw/rtl/hslp_obuf.sv
hw/rtl/http_status_line_parser.sv
sim/tb.sv
